@@ sv/cpd_pkg.sv @@
// cpd_pkg: shared types and constants for the coin pulse decoder.
// Register map codes, reset values and the result record layout.
// No dependencies.
package cpd_pkg;

   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned CsrDataWidth = 32;

   // Register index, byte address is 4 * index
   typedef enum logic [2:0] {
      REG_DEBOUNCE_MS   = 3'd0,
      REG_WINDOW_MS     = 3'd1,
      REG_PULSES_COIN_A = 3'd2,
      REG_PULSES_COIN_B = 3'd3,
      REG_PULSES_COIN_C = 3'd4,
      REG_VALUE_COIN_A  = 3'd5,
      REG_VALUE_COIN_B  = 3'd6,
      REG_VALUE_COIN_C  = 3'd7
   } cpd_reg_type;

   localparam logic [7:0]  DebounceMsReset  = 8'd20;
   localparam logic [15:0] WindowMsReset    = 16'd1000;
   localparam logic [7:0]  PulsesCoinAReset = 8'd2;
   localparam logic [7:0]  PulsesCoinBReset = 8'd4;
   localparam logic [7:0]  PulsesCoinCReset = 8'd7;
   localparam logic [7:0]  ValueCoinAReset  = 8'd1;
   localparam logic [7:0]  ValueCoinBReset  = 8'd2;
   localparam logic [7:0]  ValueCoinCReset  = 8'd5;

   localparam logic [7:0]  Max8  = 8'hFF;
   localparam logic [15:0] Max16 = 16'hFFFF;

   // Result record; selector_enable sits in bit 0
   typedef struct packed {
      logic [15:0] credit_balance;
      logic [7:0]  pulse_total;
      logic [7:0]  coin_value;
      logic        coin_done;
      logic        selector_enable;
   } cpd_rsp_type;

   localparam int unsigned RspBits      = $bits(cpd_rsp_type);
   localparam int unsigned RspDataWidth = 40;

endpackage

@@ sv/coin_pulse_decoder.sv @@
// coin_pulse_decoder: pulse-train decoder for a multi-coin acceptor.
// A result is registered into the head entry, or into the skid entry while the head is held.
// Throughput: one request per cycle while the skid entry is empty; a two-entry result
// buffer lets a new request in while one finished result waits on a stalled rsp side.
// Reset (synchronous, active high): counters, balance and buffer cleared,
// configuration registers back to their defaults.
// Depends on cpd_pkg.
module coin_pulse_decoder
   import cpd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // request stream
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // [0] falling_edge, [1] ms_tick, [7:2] zero
   // result stream
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [0] selector_enable, [1] coin_done, [9:2] coin_value, [17:10] pulse_total,
   // [33:18] credit_balance, [39:34] zero
   output logic [RspDataWidth-1:0]  rsp_tdata,
   // configuration port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CsrAddrWidth-1:0]  csr_paddr,
   input  logic [CsrDataWidth-1:0]  csr_pwdata,
   output logic [CsrDataWidth-1:0]  csr_prdata,
   output logic                     csr_pready
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [7:0]  debounce_ms_ff;
   logic [15:0] window_ms_ff;
   logic [7:0]  pulses_coin_a_ff, pulses_coin_b_ff, pulses_coin_c_ff;
   logic [7:0]  value_coin_a_ff, value_coin_b_ff, value_coin_c_ff;

   logic        csr_write;
   cpd_reg_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = cpd_reg_type'(csr_paddr[CsrAddrWidth-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ms_ff   <= DebounceMsReset;
         window_ms_ff     <= WindowMsReset;
         pulses_coin_a_ff <= PulsesCoinAReset;
         pulses_coin_b_ff <= PulsesCoinBReset;
         pulses_coin_c_ff <= PulsesCoinCReset;
         value_coin_a_ff  <= ValueCoinAReset;
         value_coin_b_ff  <= ValueCoinBReset;
         value_coin_c_ff  <= ValueCoinCReset;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_DEBOUNCE_MS:   debounce_ms_ff   <= csr_pwdata[7:0];
            REG_WINDOW_MS:     window_ms_ff     <= csr_pwdata[15:0];
            REG_PULSES_COIN_A: pulses_coin_a_ff <= csr_pwdata[7:0];
            REG_PULSES_COIN_B: pulses_coin_b_ff <= csr_pwdata[7:0];
            REG_PULSES_COIN_C: pulses_coin_c_ff <= csr_pwdata[7:0];
            REG_VALUE_COIN_A:  value_coin_a_ff  <= csr_pwdata[7:0];
            REG_VALUE_COIN_B:  value_coin_b_ff  <= csr_pwdata[7:0];
            REG_VALUE_COIN_C:  value_coin_c_ff  <= csr_pwdata[7:0];
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         REG_DEBOUNCE_MS:   csr_prdata[7:0]  = debounce_ms_ff;
         REG_WINDOW_MS:     csr_prdata[15:0] = window_ms_ff;
         REG_PULSES_COIN_A: csr_prdata[7:0]  = pulses_coin_a_ff;
         REG_PULSES_COIN_B: csr_prdata[7:0]  = pulses_coin_b_ff;
         REG_PULSES_COIN_C: csr_prdata[7:0]  = pulses_coin_c_ff;
         REG_VALUE_COIN_A:  csr_prdata[7:0]  = value_coin_a_ff;
         REG_VALUE_COIN_B:  csr_prdata[7:0]  = value_coin_b_ff;
         REG_VALUE_COIN_C:  csr_prdata[7:0]  = value_coin_c_ff;
      endcase
   end

   // ---------------------------------------------------------------
   // Decoder state
   // ---------------------------------------------------------------
   logic [7:0]  pulse_count_ff, pulse_count_in;
   logic        counting_ff, counting_in;
   logic [15:0] window_elapsed_ff, window_elapsed_in;
   logic [7:0]  since_last_ff, since_last_in;
   logic        seen_pulse_ff, seen_pulse_in;
   logic [15:0] balance_ff, balance_in;

   logic        req_accept;
   logic        edge_seen, tick;
   logic [7:0]  since_ticked;
   logic [15:0] window_ticked;
   logic        window_close;
   logic        pulse_ok;
   logic [7:0]  coin_credit;
   logic [16:0] balance_sum;
   cpd_rsp_type rsp_new;

   assign req_accept = req_tvalid & req_tready;
   assign edge_seen  = req_tdata[0];
   assign tick       = req_tdata[1];

   always_comb begin
      // tick advances both timers first (the window timer only while counting), each saturating
      since_ticked  = (tick && since_last_ff != Max8) ? since_last_ff + 8'd1 : since_last_ff;
      window_ticked = (tick && counting_ff && window_elapsed_ff != Max16)
                      ? window_elapsed_ff + 16'd1 : window_elapsed_ff;
      window_close  = counting_ff && (window_ticked >= window_ms_ff);

      // first match wins: a, then b, then c
      priority if (pulse_count_ff == pulses_coin_a_ff) coin_credit = value_coin_a_ff;
      else if (pulse_count_ff == pulses_coin_b_ff)     coin_credit = value_coin_b_ff;
      else if (pulse_count_ff == pulses_coin_c_ff)     coin_credit = value_coin_c_ff;
      else                                             coin_credit = 8'd0;

      balance_sum = {1'b0, balance_ff} + {9'd0, coin_credit};

      // saturated gap always passes debounce; first pulse since reset always passes
      pulse_ok = edge_seen && !window_close &&
                 (!seen_pulse_ff || since_ticked > debounce_ms_ff || since_ticked == Max8);

      pulse_count_in    = pulse_count_ff;
      counting_in       = counting_ff;
      window_elapsed_in = window_ticked;
      since_last_in     = since_ticked;
      seen_pulse_in     = seen_pulse_ff;
      balance_in        = balance_ff;

      rsp_new = '0;

      if (window_close) begin
         balance_in     = balance_sum[16] ? Max16 : balance_sum[15:0];
         pulse_count_in = 8'd0;
         counting_in    = 1'b0;
         rsp_new.coin_done   = 1'b1;
         rsp_new.coin_value  = coin_credit;
         rsp_new.pulse_total = pulse_count_ff;
      end else if (pulse_ok) begin
         pulse_count_in = (pulse_count_ff != Max8) ? pulse_count_ff + 8'd1 : pulse_count_ff;
         seen_pulse_in  = 1'b1;
         since_last_in  = 8'd0;
         if (!counting_ff) begin
            counting_in       = 1'b1;
            window_elapsed_in = 16'd0;
         end
      end

      rsp_new.selector_enable = ~counting_in;
      rsp_new.credit_balance  = balance_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_count_ff    <= 8'd0;
         counting_ff       <= 1'b0;
         window_elapsed_ff <= 16'd0;
         since_last_ff     <= 8'd0;
         seen_pulse_ff     <= 1'b0;
         balance_ff        <= 16'd0;
      end else if (req_accept) begin
         pulse_count_ff    <= pulse_count_in;
         counting_ff       <= counting_in;
         window_elapsed_ff <= window_elapsed_in;
         since_last_ff     <= since_last_in;
         seen_pulse_ff     <= seen_pulse_in;
         balance_ff        <= balance_in;
      end
   end

   // ---------------------------------------------------------------
   // Result buffer: head register plus one skid entry
   // ---------------------------------------------------------------
   cpd_rsp_type head_ff, skid_ff;
   logic        head_valid_ff, skid_valid_ff;
   logic        rsp_pop;

   assign req_tready = ~skid_valid_ff;
   assign rsp_pop    = rsp_tvalid & rsp_tready;
   assign rsp_tvalid = head_valid_ff;
   assign rsp_tdata  = {(RspDataWidth - RspBits)'(0), head_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_pop) begin
            head_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (req_accept) begin
         if (!head_valid_ff || rsp_pop) begin
            head_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_pop) begin
         head_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_pop) begin
            head_ff <= skid_ff;
         end
      end else if (req_accept) begin
         if (!head_valid_ff || rsp_pop) begin
            head_ff <= rsp_new;
         end else begin
            skid_ff <= rsp_new;
         end
      end
   end

`ifndef SYNTHESIS
   // skid entry only fills behind a held head
   a_skid_behind_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> head_valid_ff)
      else $error("skid entry valid without head entry");

   // idle decoder holds no pulses
   a_idle_no_count: assert property (@(posedge clock) disable iff (reset)
      !counting_ff |-> pulse_count_ff == 8'd0)
      else $error("pulse count nonzero outside a window");

   // a window can only be open after some pulse was taken
   a_counting_seen: assert property (@(posedge clock) disable iff (reset)
      counting_ff |-> seen_pulse_ff)
      else $error("window open without any accepted pulse");

   // closing a window always re-enables the selector
   a_done_enables: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1]) |-> rsp_tdata[0])
      else $error("coin done with selector still disabled");

   // balance never decreases while running
   a_balance_mono: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> balance_ff >= $past(balance_ff))
      else $error("credit balance decreased");
`endif

endmodule
